>>> hdl/spq_pkg.sv
// Shared types and constants for the sorted-insert priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 5;
   localparam int POS_WIDTH   = 4;

   typedef enum logic {
      ACTION_INSERT = 1'b0,
      ACTION_READ   = 1'b1
   } action_type;

   typedef struct packed {
      action_type                    action;
      logic signed [VALUE_WIDTH-1:0] value;
      logic [POS_WIDTH-1:0]          position;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] read_value;
      logic                          error;
      logic [COUNT_WIDTH-1:0]        entry_count;
   } rsp_type;

   // per-cell control from the top level
   typedef struct packed {
      logic insert_en;
      logic descending;
      logic occupied;
      logic at_end;
      logic taken_in;
   } cell_ctrl_type;

endpackage

>>> hdl/spq_cell.sv
// One storage cell of the sorted chain: compare, then hold, shift or load.
`timescale 1ns / 1ps

module spq_cell (
   input  logic                                    clock,
   input  spq_pkg::cell_ctrl_type                  ctrl,
   input  logic signed [spq_pkg::VALUE_WIDTH-1:0] new_value,
   input  logic signed [spq_pkg::VALUE_WIDTH-1:0] left_value,
   output logic signed [spq_pkg::VALUE_WIDTH-1:0] value,
   output logic                                    taken_out
);
   import spq_pkg::*;

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;
   logic                          stop;
   logic                          hit;

   always_comb begin
      stop = ctrl.occupied &&
             (ctrl.descending ? (value_ff <= new_value) : (value_ff >= new_value));
      hit       = stop || ctrl.at_end;
      taken_out = ctrl.taken_in || hit;
   end

   // earlier cell took the value: shift right; first hit: load new value
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert_en && ctrl.taken_in && (ctrl.occupied || ctrl.at_end)) begin
         value_in = left_value;
      end else if (ctrl.insert_en && hit) begin
         value_in = new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> hdl/sorted_insert_priority_queue_unit.sv
// Top level of the sorted-insert priority queue: cell chain, count and response register.
//
// Requests arrive on req_valid/req_ready with a req_data struct: an insert
// places value before the first stored entry that does not precede it under
// the current order; a read returns the entry at position with the count.
// Every request gives exactly one response on rsp_valid/rsp_ready.
// The response is registered at the accepting edge. Throughput is one
// request per cycle while the receiver keeps up; all 16 cells compare
// in parallel and shift in the same cycle; the response register is the only stage.
// When the receiver stalls, req_ready drops while a response waits and
// rsp_ready is low; the next request is taken in the cycle it is freed.
// Writing csr_write_enable sets descending order from csr_write_data; the
// stored entries are not re-sorted. Reset (synchronous, active high) empties
// the store and clears the response valid flag and the order bit; entry
// contents are not cleared and are never read before being written.
// Reads at or beyond the count and inserts into a full store flag error.
`timescale 1ns / 1ps

module sorted_insert_priority_queue_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);
   import spq_pkg::*;

   logic                          descending_ff;
   logic                          descending_in;
   logic [COUNT_WIDTH-1:0]        count_ff;
   logic [COUNT_WIDTH-1:0]        count_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   rsp_type                       rsp_ff;
   rsp_type                       rsp_in;

   logic                          req_fire;
   logic                          full;
   logic                          insert_en;
   logic                          read_ok;
   cell_ctrl_type                 ctrl       [DEPTH];
   logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic                          taken      [DEPTH+1];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == COUNT_WIDTH'(DEPTH));
   assign insert_en = req_fire && (req_data.action == ACTION_INSERT) && !full;
   assign read_ok   = ({1'b0, req_data.position} < count_ff);

   assign taken[0] = 1'b0;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i].insert_en  = insert_en;
         ctrl[i].descending = descending_ff;
         ctrl[i].occupied   = (COUNT_WIDTH'(i) < count_ff);
         ctrl[i].at_end     = (COUNT_WIDTH'(i) == count_ff);
         ctrl[i].taken_in   = taken[i];
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[g]),
         .new_value  (req_data.value),
         .left_value ((g == 0) ? req_data.value : cell_value[(g == 0) ? 0 : g-1]),
         .value      (cell_value[g]),
         .taken_out  (taken[g+1])
      );
   end

   always_comb begin
      descending_in = csr_write_enable ? csr_write_data : descending_ff;
      count_in      = insert_en ? count_ff + 1'b1 : count_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (req_fire) begin
         rsp_valid_in       = 1'b1;
         rsp_in.entry_count = count_in;
         rsp_in.read_value  = '0;
         rsp_in.error       = 1'b0;
         case (req_data.action)
            ACTION_INSERT: begin
               rsp_in.error = full;
            end
            ACTION_READ: begin
               rsp_in.error = !read_ok;
               if (read_ok) begin
                  rsp_in.read_value = cell_value[req_data.position];
               end
            end
            default: begin
               rsp_in.error = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         descending_ff <= descending_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("entry count beyond depth");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      insert_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not raise count");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error |-> rsp_ff.read_value == '0)
      else $error("error response carries a value");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_ff.entry_count == count_ff)
      else $error("response count differs from store count");
`endif

endmodule

>>> verif/sorted_queue_checker.sv
// Checker for the sorted-insert priority queue: shadow store, response prediction, comparison.
`timescale 1ns / 1ps

module sorted_queue_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  spq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  spq_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic             csr_write_data,
   output int               mismatch_count,
   output int               outstanding
);
   import spq_pkg::*;

   localparam int EXP_DEPTH = 8;

   logic signed [VALUE_WIDTH-1:0] shadow_entries [DEPTH];
   int                            shadow_count;
   logic                          shadow_descending;
   rsp_type                       expected_rsp [EXP_DEPTH];
   logic [2:0]                    exp_head;
   logic [2:0]                    exp_tail;
   int                            exp_count;
   rsp_type                       oldest_rsp;

   // applies one request to the shadow store and returns its response
   function automatic rsp_type next_queue_response(req_type r);
      rsp_type rsp;
      int      slot;
      bit      found;
      rsp   = '0;
      found = 1'b0;
      if (r.action == ACTION_INSERT) begin
         if (shadow_count >= DEPTH) begin
            rsp.error = 1'b1;
         end else begin
            slot = shadow_count;
            for (int i = 0; i < shadow_count; i++) begin
               if (!found && (shadow_descending ? (shadow_entries[i] <= r.value)
                                                : (shadow_entries[i] >= r.value))) begin
                  slot  = i;
                  found = 1'b1;
               end
            end
            for (int i = shadow_count; i > slot; i--) begin
               shadow_entries[i] = shadow_entries[i-1];
            end
            shadow_entries[slot] = r.value;
            shadow_count++;
         end
      end else if (r.position < shadow_count) begin
         rsp.read_value = shadow_entries[r.position];
      end else begin
         rsp.error = 1'b1;
      end
      rsp.entry_count = COUNT_WIDTH'(shadow_count);
      return rsp;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mismatch_count    = 0;
         shadow_count      = 0;
         shadow_descending = 1'b0;
         exp_head          = '0;
         exp_tail          = '0;
         exp_count         = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (exp_count == 0) begin
               mismatch_count++;
               $display("%0t: response expected none got %p", $time, rsp_data);
            end else begin
               oldest_rsp = expected_rsp[exp_head];
               exp_head   = exp_head + 3'd1;
               exp_count--;
               if (rsp_data.read_value !== oldest_rsp.read_value) begin
                  mismatch_count++;
                  $display("%0t: read_value expected %0d got %0d", $time,
                           oldest_rsp.read_value, rsp_data.read_value);
               end
               if (rsp_data.error !== oldest_rsp.error) begin
                  mismatch_count++;
                  $display("%0t: error expected %0b got %0b", $time,
                           oldest_rsp.error, rsp_data.error);
               end
               if (rsp_data.entry_count !== oldest_rsp.entry_count) begin
                  mismatch_count++;
                  $display("%0t: entry_count expected %0d got %0d", $time,
                           oldest_rsp.entry_count, rsp_data.entry_count);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (exp_count == EXP_DEPTH) begin
               mismatch_count++;
               $display("%0t: requests in flight expected at most %0d got %0d", $time,
                        EXP_DEPTH, exp_count + 1);
            end else begin
               expected_rsp[exp_tail] = next_queue_response(req_data);
               exp_tail               = exp_tail + 3'd1;
               exp_count++;
            end
         end
         if (csr_write_enable) begin
            shadow_descending = csr_write_data;
         end
      end
      outstanding = exp_count;
   end

endmodule

>>> verif/sorted_insert_priority_queue_unit_tb.sv
// Testbench top for the sorted-insert priority queue: clock, reset, request stimulus, verdict.
`timescale 1ns / 1ps

module sorted_insert_priority_queue_unit_tb;
   import spq_pkg::*;

   localparam int PHASE_ITEMS = 150;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic    csr_write_data;
   int      mismatch_count;
   int      outstanding;
   int      send_idle_pct;
   int      recv_stall_pct;

   sorted_insert_priority_queue_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   sorted_queue_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always #5 clock = ~clock;

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic req_type make_request(action_type a, logic signed [VALUE_WIDTH-1:0] v,
                                            logic [POS_WIDTH-1:0] p);
      req_type r;
      r.action   = a;
      r.value    = v;
      r.position = p;
      return r;
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(7))
         0: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
         1: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_order(logic descending);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= descending;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("sorted_insert_priority_queue_unit regression: fail");
      $finish;
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_order(1'b0);

      // empty read, extremes, equal values, then reads across and past the count
      send_request(make_request(ACTION_READ, 0, 0));
      send_request(make_request(ACTION_INSERT, {1'b1, {(VALUE_WIDTH-1){1'b0}}}, 0));
      send_request(make_request(ACTION_INSERT, {1'b0, {(VALUE_WIDTH-1){1'b1}}}, 0));
      send_request(make_request(ACTION_INSERT, 0, 0));
      send_request(make_request(ACTION_INSERT, -1, 0));
      send_request(make_request(ACTION_INSERT, 0, 15));
      send_request(make_request(ACTION_INSERT, 1, 0));
      for (int p = 0; p <= 6; p++) begin
         send_request(make_request(ACTION_READ, 0, POS_WIDTH'(p)));
      end
      send_request(make_request(ACTION_READ, '1, 15));

      // order flipped with entries stored: no re-sort
      write_order(1'b1);
      send_request(make_request(ACTION_INSERT, 5, 0));
      send_request(make_request(ACTION_INSERT, -5, 0));
      send_request(make_request(ACTION_INSERT, {1'b0, {(VALUE_WIDTH-1){1'b1}}}, 0));
      send_request(make_request(ACTION_READ, 0, 0));
      send_request(make_request(ACTION_READ, 0, 8));
      send_request(make_request(ACTION_READ, 0, 9));

      for (int ph = 0; ph < 4; ph++) begin
         write_order(ph % 2 == 0);
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(39) == 0) drain_responses();
            send_request(make_request($urandom_range(1) ? ACTION_READ : ACTION_INSERT,
                                      pick_value(), POS_WIDTH'($urandom_range(15))));
         end
      end

      drain_responses();
      if (mismatch_count == 0) begin
         $display("sorted_insert_priority_queue_unit regression: pass");
      end else begin
         $display("sorted_insert_priority_queue_unit regression: fail");
      end
      $finish;
   end

endmodule
